### src/segment_triangle_intersect_defines.svh
// ---------------------------------------------------------------------------
// Segment/triangle intersect assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication.
`define STI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sti: same-cycle check failed");

// Next-cycle implication.
`define STI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sti: next-cycle check failed");

`endif

### src/sti_pkg.sv
// ---------------------------------------------------------------------------
// Segment/triangle intersect package
// Coordinate format, arithmetic widths and pipeline depth.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sti_pkg;

  localparam int CW         = 16;            // coordinate width
  localparam int IN_FIELD_W = 48;            // one packed point
  localparam int IN_DATA_W  = 5 * IN_FIELD_W;
  localparam int OUT_DATA_W = 3 * CW;

  localparam int DIFF_W  = CW + 1;           // difference of two coordinates
  localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
  localparam int CROSS_W = PROD_W + 1;       // cross product component
  localparam int DOTP_W  = DIFF_W + CROSS_W; // one dot product term
  localparam int DOT_W   = DOTP_W + 2;       // sum of three terms
  localparam int REM_W   = DOT_W + 1;        // divider remainder

  // Stages ahead of the output register: six arithmetic, CW divider steps.
  localparam int PRE_STG = 6;
  localparam int NSTG    = PRE_STG + CW;

  typedef logic signed [CW-1:0]      coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [DOTP_W-1:0]  dotp_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [REM_W-1:0]          rem_t;
  typedef logic [CW-1:0]             mag_t;

endpackage

### src/sti_lerp_div.sv
// ---------------------------------------------------------------------------
// Segment/triangle intersect lerp divider
// Pipelined restoring division giving floor(m * num / den), one bit of m
// per stage, for num < den.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sti_lerp_div (
  input  logic          clk,
  input  logic          en,
  input  sti_pkg::rem_t num,
  input  sti_pkg::rem_t den,
  input  sti_pkg::mag_t m,
  output sti_pkg::mag_t q,
  output logic          rem_nz
);
  import sti_pkg::*;

  rem_t r_r   [CW];
  rem_t num_r [CW];
  rem_t den_r [CW];
  mag_t q_r   [CW];
  mag_t m_r   [CW];

  rem_t r_in  [CW];
  rem_t n_in  [CW];
  rem_t d_in  [CW];
  mag_t q_in  [CW];
  mag_t m_in  [CW];
  rem_t r_nxt [CW];
  mag_t q_nxt [CW];

  always_comb begin
    rem_t t0, t1, t2;
    logic ge0, ge1;
    for (int j = 0; j < CW; j++) begin
      if (j == 0) begin
        r_in[j] = '0;
        q_in[j] = '0;
        n_in[j] = num;
        d_in[j] = den;
        m_in[j] = m;
      end else begin
        r_in[j] = r_r[j-1];
        q_in[j] = q_r[j-1];
        n_in[j] = num_r[j-1];
        d_in[j] = den_r[j-1];
        m_in[j] = m_r[j-1];
      end
      // Remainder stays below den, so doubling it and adding num never
      // needs more than one subtraction each.
      t0  = {r_in[j][REM_W-2:0], 1'b0};
      ge0 = (t0 >= d_in[j]);
      t1  = ge0 ? t0 - d_in[j] : t0;
      t2  = m_in[j][CW-1-j] ? t1 + n_in[j] : t1;
      ge1 = (t2 >= d_in[j]);
      r_nxt[j] = ge1 ? t2 - d_in[j] : t2;
      q_nxt[j] = {q_in[j][CW-2:0], 1'b0} + CW'(ge0) + CW'(ge1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < CW; j++) begin
        r_r[j]   <= r_nxt[j];
        q_r[j]   <= q_nxt[j];
        num_r[j] <= n_in[j];
        den_r[j] <= d_in[j];
        m_r[j]   <= m_in[j];
      end
    end
  end

  assign q      = q_r[CW-1];
  assign rem_nz = (r_r[CW-1] != '0);

endmodule

### src/segment_triangle_intersect.sv
// ---------------------------------------------------------------------------
// Segment/triangle intersect
// Exact fixed-point test of a line segment against a triangle in 3D.
// ---------------------------------------------------------------------------
// Usage: a transfer on the in_ channel carries one query: the triangle
// corners a, b, c and the segment ends, each a packed signed 16-bit x, y, z.
// For each query one result leaves on the out_ channel: out_tuser is the hit
// flag and out_tdata the crossing point truncated toward zero (zero on a
// miss). A hit needs a strict crossing of the plane with the point inside
// the triangle or on its edges; degenerate triangles miss.
// A query passes six stages of differences, products, cross products and
// plane/edge dot products, then sixteen divider stages (one quotient bit
// each, the slowest part), then the output register, before out_tvalid.
// One query is taken every cycle while the output is not stalled.
// The whole pipeline advances together; while out_tvalid is high and
// out_tready low every stage holds and in_tready is low, so nothing is lost
// or repeated. Reset clears all valid bits and the output valid, and holds
// in_tready low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_triangle_intersect (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // vertex_a, vertex_b, vertex_c, seg_start, seg_end (48 bits each)
  input  logic [sti_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cross_x, cross_y, cross_z (16 bits each)
  output logic [sti_pkg::OUT_DATA_W-1:0]   out_tdata,
  // hit
  output logic [0:0]                       out_tuser
);
  import sti_pkg::*;

`include "segment_triangle_intersect_defines.svh"

  logic en;
  logic [NSTG-1:0] v_r;
  logic out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic out_hit_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v_r          <= {v_r[NSTG-2:0], in_tvalid};
      out_tvalid_r <= v_r[NSTG-1];
    end
  end

  // Stage 1: unpack and take differences.
  coord_t pt [5][3];
  always_comb begin
    for (int f = 0; f < 5; f++) begin
      for (int k = 0; k < 3; k++) begin
        pt[f][k] = $signed(in_tdata[f*IN_FIELD_W + k*CW +: CW]);
      end
    end
  end

  diff_t ba_r [3], ca_r [3], sa_r [3], ea_r [3];
  diff_t es_r [3], as_r [3], bs_r [3], cs_r [3];
  coord_t s1_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ba_r[k]   <= DIFF_W'(pt[1][k]) - DIFF_W'(pt[0][k]);
        ca_r[k]   <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[0][k]);
        sa_r[k]   <= DIFF_W'(pt[3][k]) - DIFF_W'(pt[0][k]);
        ea_r[k]   <= DIFF_W'(pt[4][k]) - DIFF_W'(pt[0][k]);
        es_r[k]   <= DIFF_W'(pt[4][k]) - DIFF_W'(pt[3][k]);
        as_r[k]   <= DIFF_W'(pt[0][k]) - DIFF_W'(pt[3][k]);
        bs_r[k]   <= DIFF_W'(pt[1][k]) - DIFF_W'(pt[3][k]);
        cs_r[k]   <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[3][k]);
        s1_s_r[k] <= pt[3][k];
      end
    end
  end

  // Stage 2: cross product terms. Pair 0 is the plane normal, pairs 1 to 3
  // give the edge volumes seen from the segment start.
  diff_t cu [4][3], cv [4][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cu[0][k] = ba_r[k]; cv[0][k] = ca_r[k];
      cu[1][k] = as_r[k]; cv[1][k] = bs_r[k];
      cu[2][k] = bs_r[k]; cv[2][k] = cs_r[k];
      cu[3][k] = cs_r[k]; cv[3][k] = as_r[k];
    end
  end

  prod_t pa_r [4][3], pb_r [4][3];
  diff_t s2_sa_r [3], s2_ea_r [3], s2_es_r [3];
  coord_t s2_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int k = 0; k < 3; k++) begin
          pa_r[p][k] <= PROD_W'(cu[p][(k+1)%3]) * PROD_W'(cv[p][(k+2)%3]);
          pb_r[p][k] <= PROD_W'(cu[p][(k+2)%3]) * PROD_W'(cv[p][(k+1)%3]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        s2_sa_r[k] <= sa_r[k];
        s2_ea_r[k] <= ea_r[k];
        s2_es_r[k] <= es_r[k];
        s2_s_r[k]  <= s1_s_r[k];
      end
    end
  end

  // Stage 3: cross products.
  cross_t cr_r [4][3];
  diff_t s3_sa_r [3], s3_ea_r [3], s3_es_r [3];
  coord_t s3_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int k = 0; k < 3; k++) begin
          cr_r[p][k] <= CROSS_W'(pa_r[p][k]) - CROSS_W'(pb_r[p][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        s3_sa_r[k] <= s2_sa_r[k];
        s3_ea_r[k] <= s2_ea_r[k];
        s3_es_r[k] <= s2_es_r[k];
        s3_s_r[k]  <= s2_s_r[k];
      end
    end
  end

  // Stage 4: dot product terms. Dots 0 and 1 are the plane distances of the
  // segment ends, dots 2 to 4 the edge volumes.
  diff_t dl [5][3];
  cross_t dr [5][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dl[0][k] = s3_sa_r[k]; dr[0][k] = cr_r[0][k];
      dl[1][k] = s3_ea_r[k]; dr[1][k] = cr_r[0][k];
      dl[2][k] = s3_es_r[k]; dr[2][k] = cr_r[1][k];
      dl[3][k] = s3_es_r[k]; dr[3][k] = cr_r[2][k];
      dl[4][k] = s3_es_r[k]; dr[4][k] = cr_r[3][k];
    end
  end

  dotp_t dp_r [5][3];
  diff_t s4_es_r [3];
  coord_t s4_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 5; d++) begin
        for (int k = 0; k < 3; k++) begin
          dp_r[d][k] <= DOTP_W'(dl[d][k]) * DOTP_W'(dr[d][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        s4_es_r[k] <= s3_es_r[k];
        s4_s_r[k]  <= s3_s_r[k];
      end
    end
  end

  // Stage 5: dot product sums.
  dot_t dot_r [5];
  diff_t s5_es_r [3];
  coord_t s5_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 5; d++) begin
        dot_r[d] <= DOT_W'(dp_r[d][0]) + DOT_W'(dp_r[d][1]) + DOT_W'(dp_r[d][2]);
      end
      for (int k = 0; k < 3; k++) begin
        s5_es_r[k] <= s4_es_r[k];
        s5_s_r[k]  <= s4_s_r[k];
      end
    end
  end

  // Stage 6: hit decision and divider operands.
  logic crossing, rising, hit_nxt;
  logic [2:0] edge_ok;
  dot_t abs1, abs2;
  diff_t abs_es [3];

  always_comb begin
    crossing = ((dot_r[0] < 0) && (dot_r[1] > 0)) || ((dot_r[0] > 0) && (dot_r[1] < 0));
    rising   = (dot_r[0] < 0);
    for (int j = 0; j < 3; j++) begin
      edge_ok[j] = rising ? (dot_r[2+j] >= 0) : (dot_r[2+j] <= 0);
    end
    hit_nxt = crossing && (&edge_ok);
    abs1 = (dot_r[0] < 0) ? -dot_r[0] : dot_r[0];
    abs2 = (dot_r[1] < 0) ? -dot_r[1] : dot_r[1];
    for (int k = 0; k < 3; k++) begin
      abs_es[k] = (s5_es_r[k] < 0) ? -s5_es_r[k] : s5_es_r[k];
    end
  end

  logic hit6_r;
  rem_t num_r, den_r;
  mag_t m6_r [3];
  logic neg6_r [3];
  coord_t s6_s_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      hit6_r <= hit_nxt;
      num_r  <= REM_W'($unsigned(abs1));
      den_r  <= REM_W'($unsigned(abs1)) + REM_W'($unsigned(abs2));
      for (int k = 0; k < 3; k++) begin
        m6_r[k]   <= abs_es[k][CW-1:0];
        neg6_r[k] <= s5_es_r[k][DIFF_W-1];
        s6_s_r[k] <= s5_s_r[k];
      end
    end
  end

  // Divider stages, one per axis, with the side data carried alongside.
  mag_t q [3];
  logic rem_nz [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    sti_lerp_div u_div (
      .clk    (clk),
      .en     (en),
      .num    (num_r),
      .den    (den_r),
      .m      (m6_r[g]),
      .q      (q[g]),
      .rem_nz (rem_nz[g])
    );
  end

  logic dh_r [CW];
  coord_t ds_r [CW][3];
  logic dn_r [CW][3];

  always_ff @(posedge clk) begin
    if (en) begin
      dh_r[0] <= hit6_r;
      for (int k = 0; k < 3; k++) begin
        ds_r[0][k] <= s6_s_r[k];
        dn_r[0][k] <= neg6_r[k];
      end
      for (int j = 1; j < CW; j++) begin
        dh_r[j] <= dh_r[j-1];
        for (int k = 0; k < 3; k++) begin
          ds_r[j][k] <= ds_r[j-1][k];
          dn_r[j][k] <= dn_r[j-1][k];
        end
      end
    end
  end

  // Output stage: step from the start point by the quotient, then round
  // the result toward zero when the division left a remainder.
  logic signed [CW+1:0] n [3];
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dn_r[CW-1][k]) begin
        n[k] = (CW+2)'(ds_r[CW-1][k]) - $signed({2'b00, q[k]});
        if (rem_nz[k] && (n[k] > 0)) begin
          n[k] = n[k] - (CW+2)'(1);
        end
      end else begin
        n[k] = (CW+2)'(ds_r[CW-1][k]) + $signed({2'b00, q[k]});
        if (rem_nz[k] && (n[k] < 0)) begin
          n[k] = n[k] + (CW+2)'(1);
        end
      end
      out_data_nxt[k*CW +: CW] = dh_r[CW-1] ? n[k][CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_data_nxt;
      out_hit_r   <= dh_r[CW-1];
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_hit_r;

  `STI_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata == '0)
  `STI_ASSERT_IMP(a_den_above_num, v_r[PRE_STG-1] && hit6_r, den_r > num_r)
  `STI_ASSERT_NXT(a_stall_holds, !en, $stable(v_r))
  `STI_ASSERT_NXT(a_accept_enters, in_tvalid && in_tready, v_r[0])

endmodule
